// ===== rtl/ring_indicator_pulse_sequencer_top_assert.svh =====
// Assertion macros for the ring indicator pulse sequencer checker.
`ifndef RING_INDICATOR_PULSE_SEQUENCER_TOP_ASSERT_SVH
`define RING_INDICATOR_PULSE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RIPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RIPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rips_pkg.sv =====
package rips_pkg;

    localparam int TIMER_BITS = 17;
    localparam int REG_DATA_W = 17;
    localparam int REG_ADDR_W = 4;

    // register indexes
    localparam logic [REG_ADDR_W-1:0] REG_RING_MS    = 4'd0;
    localparam logic [REG_ADDR_W-1:0] REG_RING_CNT   = 4'd1;
    localparam logic [REG_ADDR_W-1:0] REG_SMS_MS     = 4'd2;
    localparam logic [REG_ADDR_W-1:0] REG_SMS_CNT    = 4'd3;
    localparam logic [REG_ADDR_W-1:0] REG_OTHER_MS   = 4'd4;
    localparam logic [REG_ADDR_W-1:0] REG_OTHER_CNT  = 4'd5;
    localparam logic [REG_ADDR_W-1:0] REG_REL_DELAY  = 4'd6;
    localparam logic [REG_ADDR_W-1:0] REG_CLS_ENABLE = 4'd7;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // prefix indexes into the match vector
    localparam logic [1:0] PFX_RING  = 2'd0;
    localparam logic [1:0] PFX_CRING = 2'd1;
    localparam logic [1:0] PFX_CMT   = 2'd2;
    localparam logic [1:0] PFX_CMTI  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_DELAY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CLS_RING  = 2'd0,
        CLS_SMS   = 2'd1,
        CLS_OTHER = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_STARTED  = 2'd1,
        ST_DISABLED = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [10:0] ring_ms;
        logic [2:0]  ring_cnt;
        logic [10:0] sms_ms;
        logic [2:0]  sms_cnt;
        logic [10:0] other_ms;
        logic [2:0]  other_cnt;
        logic [16:0] rel_delay;
        logic [2:0]  cls_enable;
    } cfg_t;

    typedef struct packed {
        logic done;
        cls_t cls;
    } parse_t;

    typedef struct packed {
        logic    ri_level;
        logic    release_urc;
        cls_t    text_class;
        status_t start_status;
        logic    busy;
    } seq_res_t;

    // prefix text, left aligned, first character in the top byte
    function automatic logic [7:0] pfx_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [63:0] str;
        case (idx)
            PFX_RING:  str = {"RING", 32'h0};
            PFX_CRING: str = "+CRING: ";
            PFX_CMT:   str = {"+CMT: ", 16'h0};
            default:   str = {"+CMTI: ", 8'h0};
        endcase
        return str[{~pos, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] pfx_len(input logic [1:0] idx);
        case (idx)
            PFX_RING:  return 4'd4;
            PFX_CRING: return 4'd8;
            PFX_CMT:   return 4'd6;
            default:   return 4'd7;
        endcase
    endfunction

    function automatic logic [TIMER_BITS-1:0] cls_ms(input cfg_t cfg, input cls_t c);
        case (c)
            CLS_RING: return TIMER_BITS'(cfg.ring_ms);
            CLS_SMS:  return TIMER_BITS'(cfg.sms_ms);
            default:  return TIMER_BITS'(cfg.other_ms);
        endcase
    endfunction

    function automatic logic [2:0] cls_cnt(input cfg_t cfg, input cls_t c);
        case (c)
            CLS_RING: return cfg.ring_cnt;
            CLS_SMS:  return cfg.sms_cnt;
            default:  return cfg.other_cnt;
        endcase
    endfunction

    function automatic logic cls_en(input cfg_t cfg, input cls_t c);
        case (c)
            CLS_RING: return cfg.cls_enable[0];
            CLS_SMS:  return cfg.cls_enable[1];
            default:  return cfg.cls_enable[2];
        endcase
    endfunction

endpackage

// ===== rtl/rips_cfg.sv =====
module rips_cfg
    import rips_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [REG_ADDR_W-1:0] cfg_addr,
    input  logic [REG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RING_MS:    cfg_next.ring_ms    = cfg_wdata[10:0];
                REG_RING_CNT:   cfg_next.ring_cnt   = cfg_wdata[2:0];
                REG_SMS_MS:     cfg_next.sms_ms     = cfg_wdata[10:0];
                REG_SMS_CNT:    cfg_next.sms_cnt    = cfg_wdata[2:0];
                REG_OTHER_MS:   cfg_next.other_ms   = cfg_wdata[10:0];
                REG_OTHER_CNT:  cfg_next.other_cnt  = cfg_wdata[2:0];
                REG_REL_DELAY:  cfg_next.rel_delay  = cfg_wdata[16:0];
                REG_CLS_ENABLE: cfg_next.cls_enable = cfg_wdata[2:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ring_ms    <= 11'd120;
            cfg_reg.ring_cnt   <= 3'd1;
            cfg_reg.sms_ms     <= 11'd120;
            cfg_reg.sms_cnt    <= 3'd1;
            cfg_reg.other_ms   <= 11'd120;
            cfg_reg.other_cnt  <= 3'd1;
            cfg_reg.rel_delay  <= 17'd0;
            cfg_reg.cls_enable <= 3'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rips_parser.sv =====
module rips_parser
    import rips_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output parse_t     parse
);

    logic       skip_reg, skip_next;
    logic [3:0] pos_reg, pos_next;
    logic [3:0] alive_reg, alive_next;
    logic [3:0] alive_upd;
    logic [3:0] pos_upd;
    logic [3:0] hit;
    logic       take;

    assign take    = !(skip_reg && (text_byte == CHAR_CR || text_byte == CHAR_LF));
    assign pos_upd = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            alive_upd[i] = alive_reg[i];
            if (pos_reg < pfx_len(2'(i)) && text_byte != pfx_char(2'(i), pos_reg[2:0]))
                alive_upd[i] = 1'b0;
        end
    end

    // values after this byte, used for the class decision on the last byte
    logic       skip_b;
    logic [3:0] pos_b, alive_b;
    assign skip_b  = take ? 1'b0 : skip_reg;
    assign pos_b   = take ? pos_upd : pos_reg;
    assign alive_b = take ? alive_upd : alive_reg;

    always_comb begin
        for (int i = 0; i < 4; i++)
            hit[i] = alive_b[i] && (pos_b >= pfx_len(2'(i)));
    end

    always_comb begin
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        alive_next = alive_reg;
        if (byte_en) begin
            if (last_byte) begin
                skip_next  = 1'b1;
                pos_next   = 4'd0;
                alive_next = 4'hF;
            end else begin
                skip_next  = skip_b;
                pos_next   = pos_b;
                alive_next = alive_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg  <= 1'b1;
            pos_reg   <= 4'd0;
            alive_reg <= 4'hF;
        end else begin
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            alive_reg <= alive_next;
        end
    end

    assign parse.done = byte_en && last_byte;
    assign parse.cls  = (hit[1:0] != 2'b00) ? CLS_RING :
                        (hit[3:2] != 2'b00) ? CLS_SMS : CLS_OTHER;

endmodule

// ===== rtl/rips_seq.sv =====
module rips_seq
    import rips_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     tick_en,
    input  parse_t   parse,
    input  cfg_t     cfg,
    output seq_res_t res
);

    phase_t                phase_reg, phase_next;
    logic                  pin_reg, pin_next;
    logic [2:0]            pulses_reg, pulses_next;
    logic [TIMER_BITS-1:0] ms_reg, ms_next;
    cls_t                  held_reg, held_next;

    logic tick_go, expire, more, delay_zero, start_go, finish;

    assign tick_go    = tick_en && (phase_reg != PH_IDLE);
    assign expire     = (ms_reg[TIMER_BITS-1:1] == '0);
    assign more       = pulses_reg < cls_cnt(cfg, held_reg);
    assign delay_zero = (cfg.rel_delay == '0);
    assign start_go   = parse.done && (phase_reg == PH_IDLE) && cls_en(cfg, parse.cls);
    // sequence ends on this tick: delay over, or last indicate phase with no delay
    assign finish     = tick_go && expire &&
                        (phase_reg == PH_DELAY || (!pin_reg && !more && delay_zero));

    // next state
    always_comb begin
        phase_next  = phase_reg;
        pin_next    = pin_reg;
        pulses_next = pulses_reg;
        ms_next     = ms_reg;
        held_next   = held_reg;
        if (tick_go) begin
            if (!expire) begin
                ms_next = ms_reg - TIMER_BITS'(1);
            end else if (phase_reg == PH_DELAY) begin
                phase_next = PH_IDLE;
                ms_next    = '0;
            end else if (!pin_reg) begin
                pin_next = 1'b1;
                if (more) begin
                    ms_next = cls_ms(cfg, held_reg);
                end else if (!delay_zero) begin
                    phase_next = PH_DELAY;
                    ms_next    = TIMER_BITS'(cfg.rel_delay);
                end else begin
                    phase_next = PH_IDLE;
                    ms_next    = '0;
                end
            end else begin
                pulses_next = pulses_reg + 3'd1;
                pin_next    = 1'b0;
                ms_next     = cls_ms(cfg, held_reg);
            end
        end else if (start_go) begin
            held_next   = parse.cls;
            phase_next  = PH_PULSE;
            pin_next    = 1'b0;
            pulses_next = 3'd1;
            ms_next     = cls_ms(cfg, parse.cls);
        end
    end

    // outputs
    always_comb begin
        res.ri_level     = pin_next;
        res.release_urc  = finish;
        res.busy         = (phase_next != PH_IDLE);
        res.text_class   = CLS_RING;
        res.start_status = ST_NONE;
        if (parse.done) begin
            res.text_class = parse.cls;
            if (phase_reg != PH_IDLE)
                res.start_status = ST_BUSY;
            else if (!cls_en(cfg, parse.cls))
                res.start_status = ST_DISABLED;
            else
                res.start_status = ST_STARTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pin_reg    <= 1'b1;
            pulses_reg <= 3'd0;
            ms_reg     <= '0;
            held_reg   <= CLS_RING;
        end else begin
            phase_reg  <= phase_next;
            pin_reg    <= pin_next;
            pulses_reg <= pulses_next;
            ms_reg     <= ms_next;
            held_reg   <= held_next;
        end
    end

endmodule

// ===== rtl/ring_indicator_pulse_sequencer_top.sv =====
// Channel   | Dir | tdata                  | tuser      | tlast
// ----------+-----+------------------------+------------+-----------
// s_ (in)   | in  | text_byte[7:0]         | func       | last_byte
// m_ (out)  | out | ri_level, release_urc, | -          | -
//           |     | text_class, status,    |            |
//           |     | busy_res (low bit up)  |            |
// cfg_      | in  | write-only register port, index 0..7, 17-bit data
//
// Every input transaction gives exactly one result transaction, one per cycle while
// the m_ side takes them. The parser and sequencer state update at the input
// transaction and the result lands in the output register at the same edge.
// s_tready stays high while the output register is empty or being drained,
// so a stalled m_ side holds back the s_ side by one register only.
// aresetn is synchronous, active low; it restores the register defaults,
// an idle indicator (level high) and an empty output register.
module ring_indicator_pulse_sequencer_top
    import rips_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // [0] func: 0 text byte, 1 ms tick
    input  logic                  s_tlast,   // last_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] ri_level, [1] release_urc,
                                             // [3:2] text_class, [5:4] start_status,
                                             // [6] busy_res, [7] zero
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [REG_ADDR_W-1:0] cfg_addr,
    input  logic [REG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg;
    parse_t   parse;
    seq_res_t res;

    logic       s_acc;
    logic       tick_en, byte_en;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign tick_en  = s_acc && s_tuser;
    assign byte_en  = s_acc && !s_tuser;

    rips_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rips_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .text_byte (s_tdata),
        .last_byte (s_tlast),
        .parse     (parse)
    );

    rips_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (tick_en),
        .parse   (parse),
        .cfg     (cfg),
        .res     (res)
    );

    // output register: load on every input transaction, clear once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_acc) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, res.busy, res.start_status, res.text_class,
                             res.release_urc, res.ri_level};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/rips_checker.sv =====
`include "ring_indicator_pulse_sequencer_top_assert.svh"

module rips_checker
    import rips_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `RIPS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `RIPS_ASSERT_IMP(a_cls_zero, aclk, aresetn, m_tvalid && m_tdata[5:4] == ST_NONE, m_tdata[3:2] == CLS_RING, "class set without status")
    `RIPS_ASSERT_IMP(a_start_low, aclk, aresetn, m_tvalid && m_tdata[5:4] == ST_STARTED, m_tdata[6] && !m_tdata[0], "start without busy and low pin")
    `RIPS_ASSERT_IMP(a_idle_high, aclk, aresetn, m_tvalid && !m_tdata[6], m_tdata[0], "indicator low while idle")
    `RIPS_ASSERT_IMP(a_rel_idle, aclk, aresetn, m_tvalid && m_tdata[1], !m_tdata[6] && m_tdata[5:4] == ST_NONE, "release while busy")

endmodule

bind ring_indicator_pulse_sequencer_top rips_checker u_rips_checker (.*);

// ===== test/tb_ring_indicator_pulse_sequencer_top.sv =====
module tb_ring_indicator_pulse_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rips_pkg::*;

    // tuser codes on the input channel
    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // class enable bits
    localparam logic [2:0] EN_RING  = 3'b001;
    localparam logic [2:0] EN_SMS   = 3'b010;
    localparam logic [2:0] EN_OTHER = 3'b100;
    localparam logic [2:0] EN_ALL   = EN_RING | EN_SMS | EN_OTHER;

    // cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT = 5000;
    localparam int TXT_MAX    = 32;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [REG_ADDR_W-1:0] cfg_addr = '0;
    logic [REG_DATA_W-1:0] cfg_wdata = '0;

    ring_indicator_pulse_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] text_byte
        .s_tuser   (s_tuser),    // [0] func
        .s_tlast   (s_tlast),    // last_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [0] ri_level, [1] release_urc, [3:2] text_class,
                                 // [5:4] start_status, [6] busy_res
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the sequencer: registers, parser and pulse state
    // ------------------------------------------------------------------
    logic [16:0] reg_file [8];
    phase_t      seq_phase;
    logic        pin_lvl;
    logic [2:0]  pulse_cnt;
    logic [16:0] ms_left;
    logic        lead_skip;
    logic [3:0]  char_pos;
    logic [3:0]  alive_mask;      // bit0 RING, bit1 +CRING:, bit2 +CMT:, bit3 +CMTI:
    cls_t        held_cls;

    seq_res_t    pending_results [$];
    seq_res_t    head_result;
    int          fail_count = 0;

    // stimulus bookkeeping
    int          sent_items = 0;
    int          burst_left = 0;
    bit          gapless = 1'b0;
    int          seq_span = 16;   // ticks that roughly cover one full sequence
    logic [7:0]  txt_buf [TXT_MAX];
    int          txt_len = 0;

    // receiver pattern
    int          hold_req = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;

    int          idle_cycles = 0;

    function automatic string prefix_text(input int p);
        case (p)
            0:       return "RING";
            1:       return "+CRING: ";
            2:       return "+CMT: ";
            default: return "+CMTI: ";
        endcase
    endfunction

    function automatic logic [16:0] reg_mask(input logic [REG_ADDR_W-1:0] idx);
        case (idx)
            REG_RING_MS, REG_SMS_MS, REG_OTHER_MS:                  return 17'h007FF;
            REG_RING_CNT, REG_SMS_CNT, REG_OTHER_CNT, REG_CLS_ENABLE: return 17'h00007;
            default:                                                return 17'h1FFFF;
        endcase
    endfunction

    function automatic logic [16:0] class_len(input cls_t c);
        case (c)
            CLS_RING: return reg_file[REG_RING_MS];
            CLS_SMS:  return reg_file[REG_SMS_MS];
            default:  return reg_file[REG_OTHER_MS];
        endcase
    endfunction

    function automatic logic [2:0] class_count(input cls_t c);
        case (c)
            CLS_RING: return reg_file[REG_RING_CNT][2:0];
            CLS_SMS:  return reg_file[REG_SMS_CNT][2:0];
            default:  return reg_file[REG_OTHER_CNT][2:0];
        endcase
    endfunction

    function automatic logic class_enabled(input cls_t c);
        case (c)
            CLS_RING: return reg_file[REG_CLS_ENABLE][0];
            CLS_SMS:  return reg_file[REG_CLS_ENABLE][1];
            default:  return reg_file[REG_CLS_ENABLE][2];
        endcase
    endfunction

    // Advance the shadow by one input transaction and return the result it gives.
    function automatic seq_res_t sequencer_step(input logic is_tick, input logic [7:0] b,
                                                input logic last);
        seq_res_t   r;
        logic [3:0] hit;
        cls_t       c;
        status_t    st;
        string      pfx;
        r.release_urc = 1'b0;
        c   = CLS_RING;
        st  = ST_NONE;
        hit = '0;
        if (is_tick) begin
            // tick: byte and last flag are don't-care
            if (seq_phase != PH_IDLE) begin
                if (ms_left > 17'd1) begin
                    ms_left = ms_left - 17'd1;
                end else if (seq_phase == PH_DELAY) begin
                    r.release_urc = 1'b1;
                    seq_phase = PH_IDLE;
                    ms_left = '0;
                end else if (!pin_lvl) begin
                    // end of an indicate phase
                    pin_lvl = 1'b1;
                    if (pulse_cnt < class_count(held_cls)) begin
                        ms_left = class_len(held_cls);
                    end else if (reg_file[REG_REL_DELAY] != '0) begin
                        seq_phase = PH_DELAY;
                        ms_left = reg_file[REG_REL_DELAY];
                    end else begin
                        r.release_urc = 1'b1;
                        seq_phase = PH_IDLE;
                        ms_left = '0;
                    end
                end else begin
                    // end of an idle gap: next pulse
                    pulse_cnt = pulse_cnt + 3'd1;
                    pin_lvl = 1'b0;
                    ms_left = class_len(held_cls);
                end
            end
        end else begin
            if (!(lead_skip && (b == CHAR_CR || b == CHAR_LF))) begin
                lead_skip = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    pfx = prefix_text(i);
                    if (char_pos < pfx.len() && b != pfx[char_pos])
                        alive_mask[i] = 1'b0;
                end
                if (char_pos != 4'd15)
                    char_pos = char_pos + 4'd1;
            end
            if (last) begin
                for (int i = 0; i < 4; i++) begin
                    pfx = prefix_text(i);
                    if (alive_mask[i] && char_pos >= pfx.len())
                        hit[i] = 1'b1;
                end
                if (hit[1:0] != '0)
                    c = CLS_RING;
                else if (hit[3:2] != '0)
                    c = CLS_SMS;
                else
                    c = CLS_OTHER;
                if (seq_phase != PH_IDLE) begin
                    st = ST_BUSY;       // running sequence left alone
                end else if (!class_enabled(c)) begin
                    st = ST_DISABLED;
                end else begin
                    st = ST_STARTED;
                    held_cls = c;
                    seq_phase = PH_PULSE;
                    pin_lvl = 1'b0;
                    pulse_cnt = 3'd1;
                    ms_left = class_len(c);
                end
                lead_skip = 1'b1;
                char_pos = '0;
                alive_mask = 4'hF;
            end
        end
        r.ri_level = pin_lvl;
        r.text_class = (st != ST_NONE) ? c : CLS_RING;
        r.start_status = st;
        r.busy = (seq_phase != PH_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: predict at each input transaction, check each result
    // transaction against the oldest prediction, track register writes.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_file[REG_RING_MS]    = 17'd120;
            reg_file[REG_RING_CNT]   = 17'd1;
            reg_file[REG_SMS_MS]     = 17'd120;
            reg_file[REG_SMS_CNT]    = 17'd1;
            reg_file[REG_OTHER_MS]   = 17'd120;
            reg_file[REG_OTHER_CNT]  = 17'd1;
            reg_file[REG_REL_DELAY]  = 17'd0;
            reg_file[REG_CLS_ENABLE] = 17'd0;
            seq_phase  = PH_IDLE;
            pin_lvl    = 1'b1;
            pulse_cnt  = '0;
            ms_left    = '0;
            lead_skip  = 1'b1;
            char_pos   = '0;
            alive_mask = 4'hF;
            held_cls   = CLS_RING;
            pending_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                pending_results.push_back(sequencer_step(s_tuser, s_tdata, s_tlast));
            // writes land after the transaction of the same edge; indexes past 7 drop
            if (cfg_wr_en && cfg_addr <= REG_CLS_ENABLE)
                reg_file[cfg_addr[2:0]] = cfg_wdata & reg_mask(cfg_addr);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end else begin
                    head_result = pending_results.pop_front();
                    check_field("ri_level", head_result.ri_level, m_tdata[0]);
                    check_field("release_urc", head_result.release_urc, m_tdata[1]);
                    check_field("text_class", head_result.text_class, m_tdata[3:2]);
                    check_field("start_status", head_result.start_status, m_tdata[5:4]);
                    check_field("busy_res", head_result.busy, m_tdata[6]);
                end
            end
        end
    end

    // Receiver: open, choppy or sparse stretches; a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: any stretch with no transaction on either side is bounded.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One input transaction; bursts of random length with random gaps between.
    task automatic send_item(input logic func, input logic [7:0] data, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = gapless ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic put_byte(input logic [7:0] b);
        if (txt_len < TXT_MAX) begin
            txt_buf[txt_len] = b;
            txt_len++;
        end
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic send_buf();
        for (int i = 0; i < txt_len; i++)
            send_item(FUNC_TEXT, txt_buf[i], i == txt_len - 1);
    endtask

    task automatic say_text(input string s);
        txt_len = 0;
        put_str(s);
        send_buf();
    endtask

    // Sender stops and waits until every predicted result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_ADDR_W-1:0] idx, input logic [16:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // garbage above the register width must be masked off by the block
    function automatic logic [16:0] with_junk(input logic [REG_ADDR_W-1:0] idx,
                                              input logic [16:0] val);
        return (val & reg_mask(idx)) | (17'($urandom) & ~reg_mask(idx));
    endfunction

    function automatic logic [REG_ADDR_W-1:0] len_reg(input int k);
        case (k)
            0:       return REG_RING_MS;
            1:       return REG_SMS_MS;
            default: return REG_OTHER_MS;
        endcase
    endfunction

    function automatic logic [REG_ADDR_W-1:0] cnt_reg(input int k);
        case (k)
            0:       return REG_RING_CNT;
            1:       return REG_SMS_CNT;
            default: return REG_OTHER_CNT;
        endcase
    endfunction

    // Small lengths so that sequences complete often; counts cover 0..7.
    task automatic config_small(input bit all_on, input bit no_delay);
        int len, cnt, dly, span;
        seq_span = 0;
        dly = no_delay ? 0 : $urandom_range(0, 15);
        for (int k = 0; k < 3; k++) begin
            len = $urandom_range(0, 8);
            cnt = $urandom_range(0, 7);
            write_reg(len_reg(k), with_junk(len_reg(k), 17'(len)));
            write_reg(cnt_reg(k), with_junk(cnt_reg(k), 17'(cnt)));
            span = 2 * ((len == 0) ? 1 : len) * ((cnt == 0) ? 1 : cnt) + dly + 4;
            if (span > seq_span)
                seq_span = span;
        end
        write_reg(REG_REL_DELAY, 17'(dly));
        write_reg(REG_CLS_ENABLE, with_junk(REG_CLS_ENABLE,
                  all_on ? 17'(EN_ALL) : 17'($urandom_range(0, 7))));
    endtask

    task automatic config_extremes(input bit high);
        if (high) begin
            write_reg(REG_RING_MS, 17'd2000);
            write_reg(REG_RING_CNT, 17'd5);
            write_reg(REG_SMS_MS, 17'd5);
            write_reg(REG_SMS_CNT, 17'd1);
            write_reg(REG_OTHER_MS, 17'd2000);
            write_reg(REG_OTHER_CNT, 17'd7);
            write_reg(REG_REL_DELAY, 17'd120000);
            seq_span = 300;     // sequences here outlast the phase
        end else begin
            write_reg(REG_RING_MS, 17'd5);
            write_reg(REG_RING_CNT, 17'd1);
            write_reg(REG_SMS_MS, 17'd5);
            write_reg(REG_SMS_CNT, 17'd1);
            write_reg(REG_OTHER_MS, 17'd5);
            write_reg(REG_OTHER_CNT, 17'd1);
            write_reg(REG_REL_DELAY, 17'd0);
            // unmapped indexes: must not touch anything
            for (int a = 8; a < 16; a++)
                write_reg(REG_ADDR_W'(a), 17'h1FFFF);
            seq_span = 14;
        end
        write_reg(REG_CLS_ENABLE, 17'(EN_ALL));
    endtask

    // Mostly well-formed result text with random content, some broken or junk.
    task automatic build_random_text();
        int    lead, kind, cut;
        string pfx;
        txt_len = 0;
        lead = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        repeat (lead) put_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        kind = $urandom_range(0, 9);
        pfx = prefix_text($urandom_range(0, 3));
        case (kind)
            0, 1, 2, 3, 4: begin
                put_str(pfx);
                repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
            end
            5: begin
                cut = $urandom_range(1, pfx.len() - 1);
                put_str(pfx.substr(0, cut - 1));
            end
            6: begin
                put_str(pfx);
                txt_buf[lead + $urandom_range(0, pfx.len() - 1)] = 8'($urandom);
            end
            7, 8: begin
                repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
            end
            default: begin
                // nothing but line breaks before the last byte
                if (txt_len == 0)
                    put_byte(CHAR_CR);
            end
        endcase
    endtask

    task automatic random_traffic(input int n);
        int stop_at, ticks;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray transaction: lone tick or a loose byte
                send_item($urandom_range(0, 1) ? FUNC_TICK : FUNC_TEXT,
                          8'($urandom), 1'($urandom));
            end else begin
                build_random_text();
                send_buf();
                ticks = ($urandom_range(0, 3) != 0) ? $urandom_range(seq_span / 2, seq_span)
                                                    : $urandom_range(0, seq_span / 2);
                send_ticks(ticks);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset every class is disabled and the indicator idles high.
    task automatic test_reset_defaults();
        say_text("RING");
        send_ticks(2);
        wait_for_results();
    endtask

    task automatic test_directed();
        // zero length and zero count on ring, two pulses on sms, release delay 3
        write_reg(REG_RING_MS, 17'd0);
        write_reg(REG_RING_CNT, 17'd0);
        write_reg(REG_SMS_MS, 17'd1);
        write_reg(REG_SMS_CNT, 17'd2);
        write_reg(REG_OTHER_MS, 17'd2);
        write_reg(REG_OTHER_CNT, 17'd1);
        write_reg(REG_REL_DELAY, 17'd3);
        write_reg(REG_CLS_ENABLE, 17'(EN_ALL));

        // CR/LF skipped, ring starts
        txt_len = 0;
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
        put_str("RING");
        send_buf();
        say_text("+CMT: ");         // rejected busy, still classified sms
        send_ticks(4);              // pulse expires at once, then the delay
        say_text("+CMTI: ");
        send_ticks(6);
        txt_len = 0;                // empty after line break: other
        put_byte(CHAR_LF);
        send_buf();
        send_ticks(5);
        wait_for_results();

        write_reg(REG_REL_DELAY, 17'd0);
        write_reg(REG_CLS_ENABLE, 17'(EN_RING | EN_SMS));
        say_text("RIN");            // shorter than the prefix: other, disabled
        say_text("+CRING: ");
        send_item(FUNC_TICK, 8'hFF, 1'b1);
        txt_len = 0;                // byte extremes
        put_byte(8'h00);
        put_byte(8'hFF);
        send_buf();
        say_text("RING+CRING: +CMTI: x");   // position counter saturates
        send_ticks(1);
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain.
    task automatic test_backpressure();
        hold_req = 300;
        gapless = 1'b1;
        burst_left = 0;
        repeat (8) begin
            build_random_text();
            send_buf();
            send_ticks(3);
        end
        gapless = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_phase(input int p);
        wait_for_results();
        case (p)
            0:       config_small(1'b0, 1'b0);
            1:       config_small(1'b1, 1'b1);
            2:       config_extremes(1'b1);
            3:       config_extremes(1'b0);
            4:       config_small(1'b1, 1'b0);
            default: config_small(1'b0, 1'b0);
        endcase
        random_traffic(170);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random_phase(0);
        test_random_phase(1);
        test_backpressure();
        test_random_phase(2);
        test_random_phase(3);
        test_random_phase(4);
        test_random_phase(5);
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
